// ===== rtl/hse_pkg.sv =====
// Shared types, constants and a helper function of the hash set engine.
package hse_pkg;

  localparam int MAX_BUCKETS     = 256;
  localparam int SLOT_GROUPS     = 2;
  localparam int SLOTS_PER_GROUP = 4;
  localparam int SLOTS           = SLOT_GROUPS * SLOTS_PER_GROUP;
  localparam int NODE_CAPACITY   = 8;
  localparam int MIN_BUCKETS     = 16;
  localparam int CROWD_LIMIT     = NODE_CAPACITY * 7;

  localparam int BKT_W   = $clog2(MAX_BUCKETS);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int NB_W    = 9;
  localparam int FILL_W  = 4;
  localparam int TOTAL_W = 12;

  localparam logic [31:0] HASH_SEED = 32'd12138;
  localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2    = 32'h1b873593;
  localparam logic [31:0] MUR_ADD   = 32'he6546b64;
  localparam logic [31:0] MUR_LEN   = 32'd4;
  localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;

  localparam logic CFG_BUCKET_COUNT = 1'b0;
  localparam logic CFG_FROZEN       = 1'b1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FAIL   = 2'd1,
    ST_FROZEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    HINT_REMAIN = 2'd0,
    HINT_GROW   = 2'd1,
    HINT_REDUCE = 2'd2
  } hint_e;

  typedef enum logic [3:0] {
    F_IDLE, F_MIX1, F_MIX2, F_MIX3, F_MIX4, F_MIX5, F_MOD, F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE, B_SCAN, B_UPD, B_SWEEP
  } back_state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [31:0]      key;
    logic [BKT_W-1:0] bucket;
  } req_t;

  typedef struct packed {
    logic [NB_W-1:0] nb;
    logic            frozen;
    logic            recount;
  } cfg_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== rtl/hse_front.sv =====
// Front end: accepts requests, hashes the key and reduces it to a bucket.
module hse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hse_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] key_i,
  output logic               push_o,
  output hse_pkg::req_t      push_data_o,
  input  logic               full_i
);
  import hse_pkg::*;

  front_state_e state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [31:0] key_q;
  logic [1:0]  act_q;
  logic [NB_W-1:0] rem_q, rem_d;
  logic [2:0]  cnt_q;
  logic [63:0] prod;
  logic [31:0] mix;

  function automatic logic [NB_W-1:0] mod_step(logic [NB_W-1:0] r, logic [3:0] bits,
                                                logic [NB_W-1:0] d);
    logic [NB_W:0] t;
    logic [NB_W-1:0] acc;
    acc = r;
    for (int i = 3; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      acc = t[NB_W-1:0];
    end
    mod_step = acc;
  endfunction

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    rem_d   = rem_q;
    prod    = '0;
    mix     = '0;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        prod = {32'd0, key_i} * {32'd0, MUR_C1};
        h_d  = prod[31:0];
        if (in_valid_i) state_d = F_MIX1;
      end
      F_MIX1: begin
        prod    = {32'd0, rotl32(h_q, 15)} * {32'd0, MUR_C2};
        h_d     = prod[31:0];
        state_d = F_MIX2;
      end
      F_MIX2: begin
        mix     = rotl32(HASH_SEED ^ h_q, 13);
        mix     = (mix << 2) + mix + MUR_ADD;
        mix     = mix ^ MUR_LEN;
        h_d     = mix ^ (mix >> 16);
        state_d = F_MIX3;
      end
      F_MIX3: begin
        prod    = {32'd0, h_q} * {32'd0, MUR_F1};
        h_d     = prod[31:0];
        state_d = F_MIX4;
      end
      F_MIX4: begin
        mix     = h_q ^ (h_q >> 13);
        prod    = {32'd0, mix} * {32'd0, MUR_F2};
        h_d     = prod[31:0];
        state_d = F_MIX5;
      end
      F_MIX5: begin
        h_d     = h_q ^ (h_q >> 16);
        rem_d   = '0;
        state_d = F_MOD;
      end
      F_MOD: begin
        rem_d = mod_step(rem_q, h_q[31:28], cfg_i.nb);
        h_d   = h_q << 4;
        if (cnt_q == 3'd7) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_MOD) cnt_q <= cnt_q + 3'd1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    rem_q <= rem_d;
    if (state_q == F_IDLE && in_valid_i) begin
      key_q <= key_i;
      act_q <= action_i;
    end
  end

  assign in_stall_o         = (state_q != F_IDLE);
  assign push_data_o.action = act_q;
  assign push_data_o.key    = key_q;
  assign push_data_o.bucket = rem_q[BKT_W-1:0];

endmodule

// ===== rtl/hse_queue.sv =====
// Two-entry request queue between front and back end.
module hse_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hse_pkg::req_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output hse_pkg::req_t head_o,
  output logic          empty_o
);
  import hse_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign head_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

// ===== rtl/hse_back.sv =====
// Back end: scans the bucket slots, updates the set and drives results.
module hse_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hse_pkg::cfg_t               cfg_i,
  input  logic                        empty_i,
  input  hse_pkg::req_t               head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        was_present_o,
  output logic [7:0]                  bucket_index_o,
  output logic [hse_pkg::FILL_W-1:0]  bucket_fill_o,
  output logic [hse_pkg::TOTAL_W-1:0] total_entries_o,
  output logic [1:0]                  resize_hint_o
);
  import hse_pkg::*;

  back_state_e state_q, state_d;

  logic [SLOTS-1:0] vmem [MAX_BUCKETS];
  logic [31:0]      kmem [MAX_BUCKETS*SLOTS];
  logic [MAX_BUCKETS-1:0] written_q;
  logic [MAX_BUCKETS-1:0] crowded_q;

  req_t             ent_q;
  logic [SLOTS-1:0] vrd_q;
  logic             wr_q;
  logic [31:0]      krd_q;
  logic [SLOT_W:0]  j_q;
  logic             match_q;
  logic [SLOT_W-1:0] match_idx_q;
  logic [NB_W-1:0]  crowd_cnt_q;
  logic [TOTAL_W-1:0] total_q;
  logic [NB_W-1:0]  sw_q;
  logic             sweep_pend_q;
  logic             out_valid_q;
  logic [1:0]       status_q, hint_q;
  logic             present_q;
  logic [7:0]       bucket_q;
  logic [FILL_W-1:0] fill_q;

  logic [SLOTS-1:0] vword, new_vword;
  logic [SLOT_W-1:0] free_idx, rd_slot;
  logic             has_free, ins_ok, rem_ok, out_load, crowd_new;
  logic [FILL_W-1:0] fill_new;
  logic [7:0]       fill_x10;
  logic [NB_W-1:0]  crowd_cnt_new;
  logic [TOTAL_W-1:0] total_new;
  logic [1:0]       status_new, hint_new;
  logic [BKT_W-1:0] rd_bucket;
  logic             slot_hit;

  always_comb begin
    vword    = wr_q ? vrd_q : '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!vword[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    ins_ok = !cfg_i.frozen && ent_q.action == ACT_INSERT && !match_q && has_free;
    rem_ok = !cfg_i.frozen && ent_q.action == ACT_REMOVE && match_q;
    new_vword = vword;
    if (ins_ok) new_vword[free_idx] = 1'b1;
    if (rem_ok) new_vword[match_idx_q] = 1'b0;
    fill_new = '0;
    for (int i = 0; i < SLOTS; i++) fill_new = fill_new + FILL_W'(new_vword[i]);
    fill_x10  = {4'd0, fill_new} * 8'd10;
    crowd_new = fill_x10 > 8'(CROWD_LIMIT);
    crowd_cnt_new = crowd_cnt_q;
    if (crowd_new && !crowded_q[ent_q.bucket]) crowd_cnt_new = crowd_cnt_q + 1'b1;
    if (!crowd_new && crowded_q[ent_q.bucket]) crowd_cnt_new = crowd_cnt_q - 1'b1;
    total_new = total_q;
    if (ins_ok) total_new = total_q + 1'b1;
    if (rem_ok) total_new = total_q - 1'b1;
    if (cfg_i.frozen) status_new = ST_FROZEN;
    else if (ent_q.action == ACT_INSERT) status_new = ins_ok ? ST_OK : ST_FAIL;
    else if (ent_q.action == ACT_REMOVE) status_new = rem_ok ? ST_OK : ST_FAIL;
    else status_new = match_q ? ST_OK : ST_FAIL;
    if (crowd_cnt_new != '0) hint_new = HINT_GROW;
    else if (total_new < TOTAL_W'(cfg_i.nb) && total_new > TOTAL_W'(MIN_BUCKETS))
      hint_new = HINT_REDUCE;
    else hint_new = HINT_REMAIN;
  end

  assign out_load  = !out_valid_q || !out_stall_i;
  assign rd_bucket = (state_q == B_IDLE) ? head_i.bucket : ent_q.bucket;
  assign rd_slot   = j_q[SLOT_W-1:0];
  assign slot_hit  = (j_q != '0) && vword[SLOT_W'(j_q - 1'b1)] && (krd_q == ent_q.key);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (sweep_pend_q) state_d = B_SWEEP;
        else if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_SCAN;
        end
      end
      B_SCAN:  if (j_q == (SLOT_W+1)'(SLOTS)) state_d = B_UPD;
      B_UPD:   if (out_load) state_d = B_IDLE;
      B_SWEEP: if (sw_q == NB_W'(MAX_BUCKETS - 1)) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      written_q    <= '0;
      crowded_q    <= '0;
      crowd_cnt_q  <= '0;
      total_q      <= '0;
      sweep_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
      j_q          <= '0;
      sw_q         <= '0;
      match_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_UPD && out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_i.recount) sweep_pend_q <= 1'b1;
      else if (state_q == B_IDLE && sweep_pend_q) sweep_pend_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          j_q     <= '0;
          sw_q    <= '0;
          match_q <= 1'b0;
          if (sweep_pend_q) crowd_cnt_q <= '0;
        end
        B_SCAN: begin
          j_q <= j_q + 1'b1;
          if (slot_hit && !match_q) begin
            match_q     <= 1'b1;
            match_idx_q <= SLOT_W'(j_q - 1'b1);
          end
        end
        B_UPD: begin
          if (out_load) begin
            crowd_cnt_q <= crowd_cnt_new;
            total_q     <= total_new;
            crowded_q[ent_q.bucket] <= crowd_new;
            written_q[ent_q.bucket] <= 1'b1;
          end
        end
        B_SWEEP: begin
          sw_q <= sw_q + 1'b1;
          if (crowded_q[sw_q[BKT_W-1:0]] && sw_q < cfg_i.nb) crowd_cnt_q <= crowd_cnt_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_UPD && out_load) begin
      vmem[ent_q.bucket] <= new_vword;
      if (ins_ok) kmem[{ent_q.bucket, free_idx}] <= ent_q.key;
      status_q  <= status_new;
      present_q <= match_q;
      bucket_q  <= 8'(ent_q.bucket);
      fill_q    <= fill_new;
      hint_q    <= hint_new;
    end
    if (pop_o) begin
      ent_q <= head_i;
      vrd_q <= vmem[rd_bucket];
      wr_q  <= written_q[rd_bucket];
    end
    krd_q <= kmem[{rd_bucket, rd_slot}];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign was_present_o   = present_q;
  assign bucket_index_o  = bucket_q;
  assign bucket_fill_o   = fill_q;
  assign total_entries_o = total_q;
  assign resize_hint_o   = hint_q;

endmodule

// ===== rtl/bucketed_hash_set_engine.sv =====
// Top level of the bucketed hash set engine: config registers and wiring.
//
//  channel   direction  handshake                 payload
//  in        request    in_valid_i / in_stall_o   action_i, key_i
//  out       result     out_valid_o / out_stall_i status_o .. resize_hint_o
//  cfg       write      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A request passes through the front end (hash multiplies, then an
// eight-step bucket modulo) and the back end (one slot key memory read per
// slot); the front end takes no new request until it has pushed the last
// one to the queue. Reset clears all control state and the set; no clearing
// pass is needed. A write of bucket_count starts a recount of crowded buckets
// in the back end. A stalled result holds while a new request is taken in.
module bucketed_hash_set_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic signed [31:0]          key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        was_present_o,
  output logic [7:0]                  bucket_index_o,
  output logic [hse_pkg::FILL_W-1:0]  bucket_fill_o,
  output logic [hse_pkg::TOTAL_W-1:0] total_entries_o,
  output logic [1:0]                  resize_hint_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [8:0]                  cfg_data_i
);
  import hse_pkg::*;

  logic [NB_W-1:0] bucket_count_q;
  logic            frozen_q;
  logic            recount_q;
  cfg_t            cfg;
  logic            push, full, pop, empty;
  req_t            push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= NB_W'(16);
      frozen_q       <= 1'b0;
      recount_q      <= 1'b0;
    end else begin
      recount_q <= cfg_we_i && cfg_index_i == CFG_BUCKET_COUNT;
      if (cfg_we_i && cfg_index_i == CFG_BUCKET_COUNT) bucket_count_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_FROZEN) frozen_q <= cfg_data_i[0];
    end
  end

  always_comb begin
    if (bucket_count_q == '0) cfg.nb = NB_W'(1);
    else if (bucket_count_q > NB_W'(MAX_BUCKETS)) cfg.nb = NB_W'(MAX_BUCKETS);
    else cfg.nb = bucket_count_q;
    cfg.frozen  = frozen_q;
    cfg.recount = recount_q;
  end

  hse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .key_i       (key_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  hse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  hse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .was_present_o   (was_present_o),
    .bucket_index_o  (bucket_index_o),
    .bucket_fill_o   (bucket_fill_o),
    .total_entries_o (total_entries_o),
    .resize_hint_o   (resize_hint_o)
  );

endmodule

// ===== tb/hse_checker.sv =====
// Checker for the hash set engine: tracks the set, predicts each result and compares.
module hse_checker
  import hse_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [31:0]          key_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic [1:0]           status_o,
  input  logic                 was_present_o,
  input  logic [7:0]           bucket_index_o,
  input  logic [FILL_W-1:0]    bucket_fill_o,
  input  logic [TOTAL_W-1:0]   total_entries_o,
  input  logic [1:0]           resize_hint_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [8:0]           cfg_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   requests_o,
  output int                   results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         status;
    logic               present;
    logic [7:0]         bucket;
    logic [FILL_W-1:0]  fill;
    logic [TOTAL_W-1:0] total;
    logic [1:0]         hint;
  } outcome_t;

  outcome_t    outcomes_q[$];
  logic [31:0] stored_key[MAX_BUCKETS][SLOTS];
  bit          slot_used[MAX_BUCKETS][SLOTS];
  int          bucket_fill[MAX_BUCKETS];
  int          set_total;
  logic [8:0]  bucket_reg;
  logic        frozen_reg;

  function automatic logic [31:0] murmur_of(logic [31:0] k);
    logic [31:0] h;
    h = HASH_SEED;
    k = k * MUR_C1;
    k = (k << 15) | (k >> 17);
    k = k * MUR_C2;
    h = h ^ k;
    h = (h << 13) | (h >> 19);
    h = h * 32'd5 + MUR_ADD;
    h = h ^ MUR_LEN;
    h = h ^ (h >> 16);
    h = h * MUR_F1;
    h = h ^ (h >> 13);
    h = h * MUR_F2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic outcome_t apply_request(logic [1:0] act, logic [31:0] k);
    outcome_t o;
    int nb, b, match, free_slot;
    nb = (bucket_reg == 0) ? 1 : (bucket_reg > MAX_BUCKETS) ? MAX_BUCKETS : int'(bucket_reg);
    b = int'(murmur_of(k) % nb);
    match = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[b][i]) begin
        if (match < 0 && stored_key[b][i] == k) match = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    o.present = (match >= 0);
    if (frozen_reg) begin
      o.status = ST_FROZEN;
    end else if (act == ACT_INSERT) begin
      if (o.present || free_slot < 0) begin
        o.status = ST_FAIL;
      end else begin
        slot_used[b][free_slot] = 1;
        stored_key[b][free_slot] = k;
        bucket_fill[b]++;
        set_total++;
        o.status = ST_OK;
      end
    end else if (act == ACT_REMOVE) begin
      if (!o.present) begin
        o.status = ST_FAIL;
      end else begin
        slot_used[b][match] = 0;
        bucket_fill[b]--;
        set_total--;
        o.status = ST_OK;
      end
    end else begin
      o.status = o.present ? ST_OK : ST_FAIL;
    end
    o.hint = HINT_REMAIN;
    for (int i = 0; i < nb; i++)
      if (bucket_fill[i] * 10 > CROWD_LIMIT) o.hint = HINT_GROW;
    if (o.hint == HINT_REMAIN && set_total < nb && set_total > MIN_BUCKETS)
      o.hint = HINT_REDUCE;
    o.bucket = b[7:0];
    o.fill = bucket_fill[b][FILL_W-1:0];
    o.total = set_total[TOTAL_W-1:0];
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  assign pending_o = outcomes_q.size();

  initial begin
    errors_o = 0;
    requests_o = 0;
    results_o = 0;
    set_total = 0;
    bucket_reg = 9'd16;
    frozen_reg = 1'b0;
    foreach (slot_used[b, i]) slot_used[b][i] = 0;
    foreach (bucket_fill[b]) bucket_fill[b] = 0;
  end

  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_o++;
        if (outcomes_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          w = outcomes_q.pop_front();
          if (status_o !== w.status) report("status", status_o, w.status);
          if (was_present_o !== w.present) report("was_present", was_present_o, w.present);
          if (bucket_index_o !== w.bucket) report("bucket_index", bucket_index_o, w.bucket);
          if (bucket_fill_o !== w.fill) report("bucket_fill", bucket_fill_o, w.fill);
          if (total_entries_o !== w.total) report("total_entries", total_entries_o, w.total);
          if (resize_hint_o !== w.hint) report("resize_hint", resize_hint_o, w.hint);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        requests_o++;
        outcomes_q.push_back(apply_request(action_i, key_i));
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_BUCKET_COUNT) bucket_reg = cfg_data_i;
        else frozen_reg = cfg_data_i[0];
      end
    end
  end

endmodule

// ===== tb/tb_bucketed_hash_set_engine.sv =====
// Testbench top for the hash set engine: clock, reset, request stimulus and verdict.
module tb_bucketed_hash_set_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import hse_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int SETTLE = 40;
  localparam int IDLE_LIMIT = 20000;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o;
  logic [1:0]         action_i;
  logic signed [31:0] key_i;
  logic               out_valid_o, out_stall_i;
  logic [1:0]         status_o;
  logic               was_present_o;
  logic [7:0]         bucket_index_o;
  logic [FILL_W-1:0]  bucket_fill_o;
  logic [TOTAL_W-1:0] total_entries_o;
  logic [1:0]         resize_hint_o;
  logic               cfg_we_i, cfg_index_i;
  logic [8:0]         cfg_data_i;
  int                 errors, pending, requests, results;
  int                 idle_cycles;
  bit                 quiet, long_hold;
  logic [31:0]        key_pool[64];

  bucketed_hash_set_engine dut (.*);

  hse_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .key_i,
    .out_valid_o, .out_stall_i, .status_o, .was_present_o, .bucket_index_o,
    .bucket_fill_o, .total_entries_o, .resize_hint_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .requests_o(requests), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without progress", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side stalls
  initial begin
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  task automatic push(logic [1:0] act, logic [31:0] k);
    in_valid_i <= 1;
    action_i <= act;
    key_i <= k;
    do @(posedge clk_i); while (in_stall_o);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [8:0] value);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_phase(int count);
    int r;
    logic [1:0] act;
    logic [31:0] k;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      act = (r < 45) ? ACT_INSERT : (r < 70) ? ACT_REMOVE : (r < 95) ? ACT_LOOKUP : ACT_SPARE;
      k = ($urandom_range(0, 7) == 0) ? $urandom() : key_pool[$urandom_range(0, 63)];
      push(act, k);
    end
  endtask

  initial begin
    logic [8:0] sizes[7];
    in_valid_i = 0;
    action_i = ACT_INSERT;
    key_i = 0;
    cfg_we_i = 0;
    cfg_index_i = CFG_BUCKET_COUNT;
    cfg_data_i = 0;
    idle_cycles = 0;
    quiet = 0;
    long_hold = 0;
    sizes = '{9'd16, 9'd256, 9'd0, 9'd511, 9'd3, 9'd64, 9'd1};
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // single bucket: fill it, overflow, duplicates, absent keys
    cfg_write(CFG_BUCKET_COUNT, 9'd1);
    for (int i = 0; i < 9; i++) push(ACT_INSERT, key_pool[i]);
    push(ACT_INSERT, key_pool[0]);
    push(ACT_LOOKUP, key_pool[3]);
    push(ACT_LOOKUP, key_pool[20]);
    push(ACT_SPARE, key_pool[1]);
    push(ACT_REMOVE, key_pool[2]);
    push(ACT_REMOVE, key_pool[2]);
    push(ACT_INSERT, key_pool[8]);
    cfg_write(CFG_FROZEN, 9'd1);
    push(ACT_INSERT, key_pool[30]);
    push(ACT_REMOVE, key_pool[0]);
    push(ACT_LOOKUP, key_pool[1]);
    cfg_write(CFG_FROZEN, 9'd0);

    foreach (sizes[p]) begin
      cfg_write(CFG_BUCKET_COUNT, sizes[p]);
      if (p == 6) quiet = 1;
      random_phase(60);
      if (p == 1) long_hold = 1;
      if (p == 2) drain();
      random_phase(60);
    end
    cfg_write(CFG_FROZEN, 9'd1);
    random_phase(30);
    cfg_write(CFG_FROZEN, 9'd0);
    cfg_write(CFG_BUCKET_COUNT, 9'd256);
    random_phase(30);

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d requests and %0d results over bucket counts 0 to 511, frozen on and off,",
             requests, results);
    $display("with full buckets, duplicates, absent keys and the spare action code");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hse_pkg.sv
rtl/hse_front.sv
rtl/hse_queue.sv
rtl/hse_back.sv
rtl/bucketed_hash_set_engine.sv
tb/hse_checker.sv
tb/tb_bucketed_hash_set_engine.sv
